// ----- src/fwn_pkg.sv -----
`timescale 1ns / 1ps

package fwn_pkg;

  localparam logic [7:0]  ASCII_SPACE   = 8'h20;
  localparam logic [7:0]  LEAD2_MASK    = 8'hE0;
  localparam logic [7:0]  LEAD2_CODE    = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK    = 8'hF0;
  localparam logic [7:0]  LEAD3_CODE    = 8'hE0;
  localparam logic [15:0] CP_IDEO_SPACE = 16'h3000;
  localparam logic [15:0] CP_UPPER_LO   = 16'hFF21;
  localparam logic [15:0] CP_UPPER_HI   = 16'hFF3A;
  localparam logic [15:0] CP_LOWER_LO   = 16'hFF41;
  localparam logic [15:0] CP_LOWER_HI   = 16'hFF5A;
  localparam logic [15:0] CP_DIGIT_LO   = 16'hFF10;
  localparam logic [15:0] CP_DIGIT_HI   = 16'hFF19;
  localparam logic [7:0]  ASCII_UPPER_A = 8'h41;
  localparam logic [7:0]  ASCII_LOWER_A = 8'h61;
  localparam logic [7:0]  ASCII_ZERO    = 8'h30;
  localparam logic [1:0]  SEQ_LEN2      = 2'd2;
  localparam logic [1:0]  SEQ_LEN3      = 2'd3;

  // One request for the back end: up to three bytes, or a bare end marker.
  typedef struct packed {
    logic [1:0]      cnt;
    logic            has_byte;
    logic            text_end;
    logic [2:0][7:0] bytes;
  } job_t;

endpackage

// ----- src/fwn_front.sv -----
`timescale 1ns / 1ps

module fwn_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_end,
  input  logic          q_full,
  output logic          push,
  output fwn_pkg::job_t job
);

  logic [1:0]  need_r, need_nxt;
  logic [1:0]  seqlen_r, seqlen_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic [15:0] cp_full;
  logic [1:0]  need_dec;
  logic        accept;
  logic [1:0]  n;
  logic [2:0][7:0] buf_b;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cp_full  = {cp_r[9:0], in_byte[5:0]};
  assign need_dec = need_r - 2'd1;

  always_comb begin
    need_nxt   = need_r;
    seqlen_nxt = seqlen_r;
    held0_nxt  = held0_r;
    held1_nxt  = held1_r;
    cp_nxt     = cp_r;
    n          = 2'd0;
    buf_b      = '0;
    if (need_r == 2'd0) begin
      if (!in_byte[7]) begin
        if (in_byte != fwn_pkg::ASCII_SPACE) begin
          buf_b[0] = in_byte;
          n        = 2'd1;
        end
      end else if ((in_byte & fwn_pkg::LEAD2_MASK) == fwn_pkg::LEAD2_CODE) begin
        held0_nxt  = in_byte;
        cp_nxt     = {11'd0, in_byte[4:0]};
        seqlen_nxt = fwn_pkg::SEQ_LEN2;
        need_nxt   = 2'd1;
      end else if ((in_byte & fwn_pkg::LEAD3_MASK) == fwn_pkg::LEAD3_CODE) begin
        held0_nxt  = in_byte;
        cp_nxt     = {12'd0, in_byte[3:0]};
        seqlen_nxt = fwn_pkg::SEQ_LEN3;
        need_nxt   = 2'd2;
      end else begin
        buf_b[0] = in_byte;
        n        = 2'd1;
      end
    end else begin
      cp_nxt   = cp_full;
      need_nxt = need_dec;
      if (need_dec == 2'd0) begin
        if (seqlen_r == fwn_pkg::SEQ_LEN2) begin
          buf_b[0] = held0_r;
          buf_b[1] = in_byte;
          n        = 2'd2;
        end else if (cp_full == fwn_pkg::CP_IDEO_SPACE) begin
          n = 2'd0;
        end else if (cp_full inside {[fwn_pkg::CP_UPPER_LO:fwn_pkg::CP_UPPER_HI]}) begin
          buf_b[0] = fwn_pkg::ASCII_UPPER_A + (cp_full[7:0] - fwn_pkg::CP_UPPER_LO[7:0]);
          n        = 2'd1;
        end else if (cp_full inside {[fwn_pkg::CP_LOWER_LO:fwn_pkg::CP_LOWER_HI]}) begin
          buf_b[0] = fwn_pkg::ASCII_LOWER_A + (cp_full[7:0] - fwn_pkg::CP_LOWER_LO[7:0]);
          n        = 2'd1;
        end else if (cp_full inside {[fwn_pkg::CP_DIGIT_LO:fwn_pkg::CP_DIGIT_HI]}) begin
          buf_b[0] = fwn_pkg::ASCII_ZERO + (cp_full[7:0] - fwn_pkg::CP_DIGIT_LO[7:0]);
          n        = 2'd1;
        end else begin
          buf_b[0] = held0_r;
          buf_b[1] = held1_r;
          buf_b[2] = in_byte;
          n        = 2'd3;
        end
        seqlen_nxt = 2'd0;
        cp_nxt     = 16'd0;
      end else begin
        held1_nxt = in_byte;
      end
    end
    if (in_end) begin
      need_nxt   = 2'd0;
      seqlen_nxt = 2'd0;
      cp_nxt     = 16'd0;
    end
  end

  always_comb begin
    push         = accept && ((n != 2'd0) || in_end);
    job.has_byte = (n != 2'd0);
    job.cnt      = (n != 2'd0) ? n : 2'd1;
    job.text_end = in_end;
    job.bytes    = buf_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r   <= 2'd0;
      seqlen_r <= 2'd0;
      cp_r     <= 16'd0;
    end else if (accept) begin
      need_r   <= need_nxt;
      seqlen_r <= seqlen_nxt;
      cp_r     <= cp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
  end

endmodule

// ----- src/fwn_queue.sv -----
`timescale 1ns / 1ps

module fwn_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fwn_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output fwn_pkg::job_t head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  fwn_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- src/fwn_back.sv -----
`timescale 1ns / 1ps

module fwn_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  fwn_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_has_byte,
  output logic          out_run_last,
  output logic          out_text_end
);

  logic       valid_r;
  logic [1:0] idx_r;
  logic [7:0] byte_r;
  logic       has_r, last_r, end_r;
  logic       load, is_last;

  assign load    = head_valid && (!valid_r || out_ready);
  assign is_last = (idx_r == head_job.cnt - 2'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head_job.bytes[idx_r];
      has_r  <= head_job.has_byte;
      last_r <= is_last;
      end_r  <= is_last && head_job.text_end;
    end
  end

  assign out_valid    = valid_r;
  assign out_byte     = byte_r;
  assign out_has_byte = has_r;
  assign out_run_last = last_r;
  assign out_text_end = end_r;

endmodule

// ----- src/fullwidth_utf8_normalizer.sv -----
`timescale 1ns / 1ps

// Fullwidth-to-ASCII UTF-8 normaliser. Takes one text byte per request, with
// in_end on the last byte of a text, and returns normalised bytes one per
// request: ASCII spaces and U+3000 are dropped, fullwidth letters and digits
// become ASCII, other sequences pass through whole; a text whose end yields
// no byte gives one bare end marker (out_has_byte low). A byte is accepted
// every cycle while the job queue (QUEUE_DEPTH entries) has room; the output
// side delivers one result per cycle while out_ready is high, so a three-byte
// pass-through gives three output results, and sustained input rate is one
// byte per cycle when the average output is at most one byte per input. An
// input byte passes through the job queue and then the output register.
module fullwidth_utf8_normalizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_run_last,
  output logic       out_text_end
);

  fwn_pkg::job_t push_job, head_job;
  logic          push, q_full, pop, head_valid;

  fwn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_end   (in_end),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  fwn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  fwn_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end)
  );

endmodule
